FILE: rtl/bond_heat_flow_accumulator_assert.svh
// Assertion macros shared by the heat flow accumulator RTL.
`ifndef BOND_HEAT_FLOW_ACCUMULATOR_ASSERT_SVH
`define BOND_HEAT_FLOW_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BHFA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BHFA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: rtl/bhfa_pkg.sv
// Constants, types and helper functions of the heat flow accumulator.
package bhfa_pkg;

   localparam int REQ_TDATA_W = 184;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // 6/pi in unsigned Q.32.
   localparam logic [32:0] SIX_OVER_PI_Q32 = 33'd8202783307;
   localparam logic [16:0] DAMAGE_ONE      = 17'h10000;
   localparam logic [63:0] SIGN64          = 64'h8000_0000_0000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONDUCTIVITY     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BED_CONDUCTIVITY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BED_TEMPERATURE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_DIMENSIONAL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BED_FLOW_ENABLE  = 3'd4;

   typedef logic [63:0] word_type;

   // Magnitude of a 33-bit two's complement value.
   function automatic logic [32:0] abs33(input logic [32:0] v);
      logic [32:0] r;
      r = v[32] ? (33'd0 - v) : v;
      return r;
   endfunction

endpackage

FILE: rtl/bond_heat_flow_accumulator.sv
// Peridynamic bond heat flow accumulator built around one shared multiplier.
//
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tdata: node or bond fields, tuser: kind, tlast
// rsp      out  rsp_tvalid/tready    tdata: heat flow Q31.32, tuser: fault
// csr      in   csr_we               csr_index, csr_wdata
//
// A header loads the node fields and clears the sum and the fault. A bond runs up
// to fifteen products on the shared 32x32 multiplier, and the square root takes
// 34 steps and the divider 33+FRAC_BITS steps.
// Reset is synchronous and clears control, configuration and node state.
// The result sits in an output register; the next item is taken while it waits,
// and only a finishing item stalls until that register is free.
`include "bond_heat_flow_accumulator_assert.svh"

module bond_heat_flow_accumulator #(
   parameter int FRAC_BITS     = 16,
   parameter int SUM_FRAC_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, pos_z, temperature, extent, detached, damage, zero fill
   input  logic [bhfa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // heat_flow
   output logic [bhfa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // fault
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [bhfa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bhfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FINAL_SHIFT = FRAC_BITS + 32 - SUM_FRAC_BITS;
   localparam int NUM_W       = 33 + FRAC_BITS;
   localparam int SQRT_STEPS  = 34;
   localparam int CNT_W       = $clog2(NUM_W + 1);

   localparam logic [5:0] SH_NONE = 6'd0;
   localparam logic [5:0] SH_FRAC = 6'(FRAC_BITS);
   localparam logic [5:0] SH_DMG  = 6'd16;
   localparam logic [5:0] SH_FIN  = 6'(FINAL_SHIFT);

   localparam logic [NUM_W-1:0] KERN_NUM =
      {bhfa_pkg::SIX_OVER_PI_Q32, {FRAC_BITS{1'b0}}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NEXT = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_MULF = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam logic [3:0] SP_SQX  = 4'd0;
   localparam logic [3:0] SP_SQY  = 4'd1;
   localparam logic [3:0] SP_SQZ  = 4'd2;
   localparam logic [3:0] SP_ROOT = 4'd3;
   localparam logic [3:0] SP_H2   = 4'd4;
   localparam logic [3:0] SP_H3   = 4'd5;
   localparam logic [3:0] SP_H4   = 4'd6;
   localparam logic [3:0] SP_DEN  = 4'd7;
   localparam logic [3:0] SP_DIV  = 4'd8;
   localparam logic [3:0] SP_BED  = 4'd9;
   localparam logic [3:0] SP_BOND = 4'd10;
   localparam logic [3:0] SP_W    = 4'd11;
   localparam logic [3:0] SP_LAM  = 4'd12;
   localparam logic [3:0] SP_DT   = 4'd13;
   localparam logic [3:0] SP_SUM  = 4'd14;

   // Control, configuration and node state.
   logic [2:0]  st_ff, st_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  pp_ff, pp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] cond_ff, cond_in;
   logic [31:0] bed_cond_ff, bed_cond_in;
   logic [31:0] bed_temp_ff, bed_temp_in;
   logic        two_d_ff, two_d_in;
   logic        bed_en_ff, bed_en_in;
   logic [31:0] node_x_ff, node_x_in;
   logic [31:0] node_y_ff, node_y_in;
   logic [31:0] node_z_ff, node_z_in;
   logic [31:0] node_t_ff, node_t_in;
   logic [30:0] node_h_ff, node_h_in;
   logic        node_det_ff, node_det_in;
   logic [63:0] sum_ff, sum_in;
   logic        fault_ff, fault_in;

   // Datapath registers.
   logic [31:0] b_x_ff, b_x_in, b_y_ff, b_y_in, b_z_ff, b_z_in, b_t_ff, b_t_in;
   logic [30:0] b_vol_ff, b_vol_in;
   logic        b_det_ff, b_det_in;
   logic [16:0] b_dmg_ff, b_dmg_in;
   logic        last_ff, last_in;
   bhfa_pkg::word_type mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, mul_res_ff, mul_res_in;
   logic [5:0]  mul_sh_ff, mul_sh_in;
   logic [1:0]  pp_prev_ff, pp_prev_in;
   logic [63:0] prod_ff, prod_in;
   logic [127:0] acc_ff, acc_in;
   logic [67:0] sq_ff, sq_in;
   logic [67:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [63:0] drem_ff, drem_in;
   bhfa_pkg::word_type den_ff, den_in;
   logic [16:0] term_w_ff, term_w_in;
   logic [31:0] term_lm_ff, term_lm_in;
   logic [32:0] term_dm_ff, term_dm_in;
   logic        term_neg_ff, term_neg_in;
   logic        term_bed_ff, term_bed_in;
   logic [63:0] out_flow_ff, out_flow_in;
   logic        out_fault_ff, out_fault_in;

   // Combinational helpers.
   logic        req_xfer;
   logic [31:0] a_half, b_half;
   logic [1:0]  pp_pos;
   logic [127:0] pp_wide, acc_shr;
   logic [36:0] sq_rem_sh, sq_trial;
   logic [64:0] dv_sh;
   logic [32:0] mag_x, mag_y, mag_z, dt_bond, dt_bed;
   logic [33:0] z_mirror;
   logic        bed_hit;
   logic [63:0] sum_u;
   logic [63:0] kern;

   assign req_tready = (st_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_flow_ff;
   assign rsp_tuser  = out_fault_ff;

   assign a_half  = pp_ff[1] ? mul_a_ff[63:32] : mul_a_ff[31:0];
   assign b_half  = pp_ff[0] ? mul_b_ff[63:32] : mul_b_ff[31:0];
   assign prod_in = 64'(a_half) * 64'(b_half);
   assign pp_prev_in = pp_ff[1:0];
   assign pp_pos  = {1'b0, pp_prev_ff[1]} + {1'b0, pp_prev_ff[0]};
   assign pp_wide = {64'd0, prod_ff} << {pp_pos, 5'd0};
   assign acc_shr = acc_ff >> mul_sh_ff;

   assign sq_rem_sh = {rem_ff, rad_ff[67:66]};
   assign sq_trial  = {1'b0, root_ff, 2'b01};
   assign dv_sh     = {drem_ff, num_ff[NUM_W-1]};

   assign mag_x   = bhfa_pkg::abs33({b_x_ff[31], b_x_ff} - {node_x_ff[31], node_x_ff});
   assign mag_y   = bhfa_pkg::abs33({b_y_ff[31], b_y_ff} - {node_y_ff[31], node_y_ff});
   assign mag_z   = bhfa_pkg::abs33({b_z_ff[31], b_z_ff} - {node_z_ff[31], node_z_ff});
   assign dt_bond = {b_t_ff[31], b_t_ff} - {node_t_ff[31], node_t_ff};
   assign dt_bed  = {bed_temp_ff[31], bed_temp_ff} - {node_t_ff[31], node_t_ff};
   assign z_mirror = ({{2{node_z_ff[31]}}, node_z_ff} << 1) - {{2{b_z_ff[31]}}, b_z_ff};
   // Mirrored bed term: node sits below its horizon and below the neighbour,
   // and the neighbour's mirror image lies at or under the bed.
   assign bed_hit = bed_en_ff
      && ($signed({node_z_ff[31], node_z_ff}) < $signed({2'b00, node_h_ff}))
      && ($signed(node_z_ff) < $signed(b_z_ff))
      && (z_mirror[33] || (z_mirror == 34'd0));
   assign sum_u = sum_ff ^ bhfa_pkg::SIGN64;
   assign kern  = 64'(num_ff);

   always_comb begin
      st_in = st_ff;  step_in = step_ff;  pp_in = pp_ff;  cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cond_in = cond_ff;  bed_cond_in = bed_cond_ff;  bed_temp_in = bed_temp_ff;
      two_d_in = two_d_ff;  bed_en_in = bed_en_ff;
      node_x_in = node_x_ff;  node_y_in = node_y_ff;  node_z_in = node_z_ff;
      node_t_in = node_t_ff;  node_h_in = node_h_ff;  node_det_in = node_det_ff;
      sum_in = sum_ff;  fault_in = fault_ff;
      b_x_in = b_x_ff;  b_y_in = b_y_ff;  b_z_in = b_z_ff;  b_t_in = b_t_ff;
      b_vol_in = b_vol_ff;  b_det_in = b_det_ff;  b_dmg_in = b_dmg_ff;
      last_in = last_ff;
      mul_a_in = mul_a_ff;  mul_b_in = mul_b_ff;  mul_res_in = mul_res_ff;
      mul_sh_in = mul_sh_ff;  acc_in = acc_ff;  sq_in = sq_ff;
      rad_in = rad_ff;  rem_in = rem_ff;  root_in = root_ff;
      num_in = num_ff;  drem_in = drem_ff;  den_in = den_ff;
      term_w_in = term_w_ff;  term_lm_in = term_lm_ff;  term_dm_in = term_dm_ff;
      term_neg_in = term_neg_ff;  term_bed_in = term_bed_ff;
      out_flow_in = out_flow_ff;  out_fault_in = out_fault_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            bhfa_pkg::CSR_CONDUCTIVITY:     cond_in     = csr_wdata;
            bhfa_pkg::CSR_BED_CONDUCTIVITY: bed_cond_in = csr_wdata;
            bhfa_pkg::CSR_BED_TEMPERATURE:  bed_temp_in = csr_wdata;
            bhfa_pkg::CSR_TWO_DIMENSIONAL:  two_d_in    = csr_wdata[0];
            bhfa_pkg::CSR_BED_FLOW_ENABLE:  bed_en_in   = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (st_ff)
         S_IDLE: begin
            if (req_xfer) begin
               last_in  = req_tlast;
               b_x_in   = req_tdata[31:0];
               b_y_in   = req_tdata[63:32];
               b_z_in   = req_tdata[95:64];
               b_t_in   = req_tdata[127:96];
               b_vol_in = req_tdata[158:128];
               b_det_in = req_tdata[159];
               b_dmg_in = req_tdata[176:160];
               if (!req_tuser) begin
                  node_x_in   = req_tdata[31:0];
                  node_y_in   = req_tdata[63:32];
                  node_z_in   = req_tdata[95:64];
                  node_t_in   = req_tdata[127:96];
                  node_h_in   = req_tdata[158:128];
                  node_det_in = req_tdata[159];
                  sum_in      = 64'd0;
                  fault_in    = 1'b0;
                  st_in       = S_DONE;
               end else if (node_det_ff) begin
                  st_in = S_DONE;
               end else begin
                  st_in   = S_NEXT;
                  step_in = SP_SQX;
               end
            end
         end
         S_MUL: begin
            if (pp_ff != 3'd0) begin
               acc_in = acc_ff + pp_wide;
            end
            pp_in = pp_ff + 3'd1;
            if (pp_ff == 3'd4) begin
               st_in = S_MULF;
            end
         end
         S_MULF: begin
            mul_res_in = (|acc_shr[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_shr[63:0];
            st_in = S_NEXT;
         end
         S_SQRT: begin
            rad_in = rad_ff << 2;
            if (sq_rem_sh >= sq_trial) begin
               rem_in  = 35'(sq_rem_sh - sq_trial);
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               rem_in  = 35'(sq_rem_sh);
               root_in = {root_ff[32:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               st_in = S_NEXT;
            end
         end
         S_DIV: begin
            if (dv_sh >= {1'b0, den_ff}) begin
               drem_in = 64'(dv_sh - {1'b0, den_ff});
               num_in  = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_in = dv_sh[63:0];
               num_in  = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               st_in = S_NEXT;
            end
         end
         S_DONE: begin
            if (!last_ff) begin
               st_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_flow_in  = node_det_ff ? 64'd0 : sum_ff;
               out_fault_in = !node_det_ff && fault_ff;
               sum_in       = 64'd0;
               fault_in     = 1'b0;
               st_in        = S_IDLE;
            end
         end
         S_NEXT: begin
            // Most steps launch one product on the shared multiplier.
            st_in  = S_MUL;
            pp_in  = 3'd0;
            acc_in = 128'd0;
            unique case (step_ff)
               SP_SQX: begin
                  if (node_h_ff == 31'd0) begin
                     fault_in = 1'b1;
                     st_in    = S_DONE;
                  end
                  mul_a_in = 64'(mag_x);  mul_b_in = 64'(mag_x);  mul_sh_in = SH_NONE;
                  step_in  = SP_SQY;
               end
               SP_SQY: begin
                  sq_in    = acc_ff[67:0];
                  mul_a_in = 64'(mag_y);  mul_b_in = 64'(mag_y);  mul_sh_in = SH_NONE;
                  step_in  = SP_SQZ;
               end
               SP_SQZ: begin
                  sq_in    = sq_ff + acc_ff[67:0];
                  mul_a_in = 64'(mag_z);  mul_b_in = 64'(mag_z);  mul_sh_in = SH_NONE;
                  step_in  = SP_ROOT;
               end
               SP_ROOT: begin
                  rad_in  = sq_ff + acc_ff[67:0];
                  rem_in  = 35'd0;
                  root_in = 34'd0;
                  cnt_in  = CNT_W'(SQRT_STEPS);
                  st_in   = S_SQRT;
                  step_in = SP_H2;
               end
               SP_H2: begin
                  if (root_ff == 34'd0) begin
                     fault_in = 1'b1;
                     st_in    = S_DONE;
                  end
                  mul_a_in = 64'(node_h_ff);  mul_b_in = 64'(node_h_ff);
                  mul_sh_in = SH_FRAC;
                  step_in  = SP_H3;
               end
               SP_H3: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(node_h_ff);  mul_sh_in = SH_FRAC;
                  step_in  = two_d_ff ? SP_DEN : SP_H4;
               end
               SP_H4: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(node_h_ff);  mul_sh_in = SH_FRAC;
                  step_in  = SP_DEN;
               end
               SP_DEN: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(root_ff);  mul_sh_in = SH_FRAC;
                  step_in  = SP_DIV;
               end
               SP_DIV: begin
                  // A denominator that truncated to zero counts as one LSB.
                  den_in  = (mul_res_ff == 64'd0) ? 64'd1 : mul_res_ff;
                  num_in  = KERN_NUM;
                  drem_in = 64'd0;
                  cnt_in  = CNT_W'(NUM_W);
                  st_in   = S_DIV;
                  step_in = SP_BED;
               end
               SP_BED: begin
                  if (bed_hit) begin
                     term_w_in   = bhfa_pkg::DAMAGE_ONE;
                     term_lm_in  = 32'(bhfa_pkg::abs33({bed_cond_ff[31], bed_cond_ff}));
                     term_dm_in  = bhfa_pkg::abs33(dt_bed);
                     term_neg_in = bed_cond_ff[31] ^ dt_bed[32];
                     term_bed_in = 1'b1;
                     mul_a_in = kern;  mul_b_in = 64'(b_vol_ff);  mul_sh_in = SH_FRAC;
                     step_in  = SP_W;
                  end else begin
                     st_in   = S_NEXT;
                     step_in = SP_BOND;
                  end
               end
               SP_BOND: begin
                  if (b_det_ff) begin
                     st_in = S_DONE;
                  end
                  term_w_in   = (b_dmg_ff >= bhfa_pkg::DAMAGE_ONE) ? 17'd0
                                : bhfa_pkg::DAMAGE_ONE - b_dmg_ff;
                  term_lm_in  = 32'(bhfa_pkg::abs33({cond_ff[31], cond_ff}));
                  term_dm_in  = bhfa_pkg::abs33(dt_bond);
                  term_neg_in = cond_ff[31] ^ dt_bond[32];
                  term_bed_in = 1'b0;
                  mul_a_in = kern;  mul_b_in = 64'(b_vol_ff);  mul_sh_in = SH_FRAC;
                  step_in  = SP_W;
               end
               SP_W: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(term_w_ff);  mul_sh_in = SH_DMG;
                  step_in  = SP_LAM;
               end
               SP_LAM: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(term_lm_ff);  mul_sh_in = SH_FRAC;
                  step_in  = SP_DT;
               end
               SP_DT: begin
                  mul_a_in = mul_res_ff;  mul_b_in = 64'(term_dm_ff);  mul_sh_in = SH_FIN;
                  step_in  = SP_SUM;
               end
               SP_SUM: begin
                  // Saturating subtract in offset-binary form.
                  if (!term_neg_ff) begin
                     sum_in = ((mul_res_ff > sum_u) ? 64'd0 : sum_u - mul_res_ff)
                              ^ bhfa_pkg::SIGN64;
                  end else begin
                     sum_in = ((mul_res_ff > ~sum_u) ? 64'hFFFF_FFFF_FFFF_FFFF
                              : sum_u + mul_res_ff) ^ bhfa_pkg::SIGN64;
                  end
                  if (term_bed_ff) begin
                     st_in   = S_NEXT;
                     step_in = SP_BOND;
                  end else begin
                     st_in = S_DONE;
                  end
               end
               default: st_in = S_DONE;
            endcase
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;  step_ff <= SP_SQX;  pp_ff <= 3'd0;  cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cond_ff <= 32'h0001_0000;  bed_cond_ff <= 32'd0;  bed_temp_ff <= 32'd0;
         two_d_ff <= 1'b0;  bed_en_ff <= 1'b0;
         node_x_ff <= 32'd0;  node_y_ff <= 32'd0;  node_z_ff <= 32'd0;
         node_t_ff <= 32'd0;  node_h_ff <= 31'd0;  node_det_ff <= 1'b0;
         sum_ff <= 64'd0;  fault_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  step_ff <= step_in;  pp_ff <= pp_in;  cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cond_ff <= cond_in;  bed_cond_ff <= bed_cond_in;  bed_temp_ff <= bed_temp_in;
         two_d_ff <= two_d_in;  bed_en_ff <= bed_en_in;
         node_x_ff <= node_x_in;  node_y_ff <= node_y_in;  node_z_ff <= node_z_in;
         node_t_ff <= node_t_in;  node_h_ff <= node_h_in;  node_det_ff <= node_det_in;
         sum_ff <= sum_in;  fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      b_x_ff <= b_x_in;  b_y_ff <= b_y_in;  b_z_ff <= b_z_in;  b_t_ff <= b_t_in;
      b_vol_ff <= b_vol_in;  b_det_ff <= b_det_in;  b_dmg_ff <= b_dmg_in;
      last_ff <= last_in;
      mul_a_ff <= mul_a_in;  mul_b_ff <= mul_b_in;  mul_res_ff <= mul_res_in;
      mul_sh_ff <= mul_sh_in;  pp_prev_ff <= pp_prev_in;  prod_ff <= prod_in;
      acc_ff <= acc_in;  sq_ff <= sq_in;
      rad_ff <= rad_in;  rem_ff <= rem_in;  root_ff <= root_in;
      num_ff <= num_in;  drem_ff <= drem_in;  den_ff <= den_in;
      term_w_ff <= term_w_in;  term_lm_ff <= term_lm_in;  term_dm_ff <= term_dm_in;
      term_neg_ff <= term_neg_in;  term_bed_ff <= term_bed_in;
      out_flow_ff <= out_flow_in;  out_fault_ff <= out_fault_in;
   end

   `BHFA_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_xfer, st_ff != S_IDLE)
   `BHFA_ASSERT_NXT(a_mul_finishes, clock, reset, (st_ff == S_MUL) && (pp_ff == 3'd4), st_ff == S_MULF)
   `BHFA_ASSERT_IMP(a_div_nonzero, clock, reset, st_ff == S_DIV, den_ff != 64'd0)
   `BHFA_ASSERT_NXT(a_done_holds, clock, reset, (st_ff == S_DONE) && last_ff && rsp_valid_ff && !rsp_tready, st_ff == S_DONE)

endmodule
